// ===== sv/gbn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the go-back-N link endpoint.
// Used by the interfaces, the front and back modules, the top level and the checker.
package gbn_pkg;

    localparam int MAX_SEQ_NUM  = 7;
    localparam int SEQ_W        = $clog2(MAX_SEQ_NUM + 1);
    localparam int PAYLOAD_BITS = 32;
    localparam int SEQ_DEPTH    = MAX_SEQ_NUM + 1;

    typedef logic [SEQ_W-1:0]        t_seq;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;

    typedef enum logic [1:0] {
        OP_PACKET    = 2'd0,
        OP_FRAME     = 2'd1,
        OP_CKSUM_ERR = 2'd2,
        OP_TIMEOUT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // One classified event waiting for the back end.
    typedef struct packed {
        t_op      op;
        t_seq     rx_seq;
        t_seq     rx_ack;
        t_payload payload;
    } t_cmd;

    typedef struct packed {
        t_kind    kind;
        t_seq     frame_seq;
        t_seq     frame_ack;
        t_payload payload_out;
        t_seq     freed_count;
        logic     data_mismatch;
        logic     ack_out_of_range;
        logic     checksum_error;
        logic     window_full_drop;
        logic     network_enable;
        logic     last;
    } t_result;

    // True when x lies in the circular window [lo, hi).
    function automatic logic in_window(input t_seq lo, input t_seq x, input t_seq hi);
        begin
            in_window = ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
                        ((x < hi) && (hi < lo));
        end
    endfunction

endpackage

// ===== sv/gbn_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for event words in and result words out.
// Depends on gbn_pkg for field widths.
interface gbn_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic [gbn_pkg::SEQ_W-1:0]  rx_seq;
    logic [gbn_pkg::SEQ_W-1:0]  rx_ack;
    logic [gbn_pkg::PAYLOAD_BITS-1:0] payload_in;

    modport source (output valid, operation, rx_seq, rx_ack, payload_in, input ready);
    modport sink   (input valid, operation, rx_seq, rx_ack, payload_in, output ready);
endinterface

interface gbn_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 result_kind;
    logic [gbn_pkg::SEQ_W-1:0]  frame_seq;
    logic [gbn_pkg::SEQ_W-1:0]  frame_ack;
    logic [gbn_pkg::PAYLOAD_BITS-1:0] payload_out;
    logic [gbn_pkg::SEQ_W-1:0]  freed_count;
    logic                       data_mismatch;
    logic                       ack_out_of_range;
    logic                       checksum_error;
    logic                       window_full_drop;
    logic                       network_enable;
    logic                       last;

    modport source (output valid, result_kind, frame_seq, frame_ack, payload_out,
                    freed_count, data_mismatch, ack_out_of_range, checksum_error,
                    window_full_drop, network_enable, last, input ready);
    modport sink   (input valid, result_kind, frame_seq, frame_ack, payload_out,
                    freed_count, data_mismatch, ack_out_of_range, checksum_error,
                    window_full_drop, network_enable, last, output ready);
endinterface

// ===== sv/go_back_n_link_endpoint_core.sv =====
`timescale 1ns / 1ps
// Go-back-N link endpoint with piggybacked acks, eight sequence numbers and up to
// seven frames outstanding. Event words enter a two-word queue; packet, frame-arrival,
// checksum-error and empty-timeout events each produce one result word; the back end
// takes a new event while idle and its result register is free. A timeout with n frames
// outstanding produces n send words, oldest first, each through a read state and then
// an emit state, set by the registered read of the send buffer; no event is taken meanwhile.
// The caller runs the retransmit timers.
// Depends on gbn_pkg, gbn_if, gbn_front and gbn_back.
module go_back_n_link_endpoint_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out
);
    import gbn_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    gbn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    gbn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_out       (o_out)
    );

endmodule

// ===== sv/gbn_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts event words, decodes the operation and queues them.
// Depends on gbn_pkg and gbn_in_if.
module gbn_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gbn_in_if.sink         i_in,
    output logic           o_cmd_valid,
    output gbn_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_ready
);
    import gbn_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.op      = t_op'(i_in.operation);
        w_cmd.rx_seq  = i_in.rx_seq;
        w_cmd.rx_ack  = i_in.rx_ack;
        w_cmd.payload = i_in.payload_in;
    end

    assign i_in.ready  = (r_count != 2'(QDEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== sv/gbn_back.sv =====
`timescale 1ns / 1ps
// Back end: window state, send buffer, retransmit sequencer and result register.
// Depends on gbn_pkg and gbn_out_if.
module gbn_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  gbn_pkg::t_cmd  i_cmd,
    output logic           o_cmd_ready,
    gbn_out_if.source      o_out
);
    import gbn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state   r_state, n_state;
    t_seq     r_next_send, n_next_send;
    t_seq     r_oldest, n_oldest;
    t_seq     r_expected, n_expected;
    t_seq     r_count, n_count;
    t_seq     r_ptr, n_ptr;
    t_seq     r_left, n_left;
    logic     r_out_valid, n_out_valid;
    t_result  r_out, n_out;
    t_payload r_rd_data;
    t_payload r_send_buf [SEQ_DEPTH];

    logic     w_out_free;
    logic     w_load;
    logic     w_buf_we;
    logic     w_full;
    logic     w_in_win;
    logic     w_seq_ok;
    t_seq     w_freed;
    t_seq     w_ack;
    t_result  w_res;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_full     = (r_count >= SEQ_W'(MAX_SEQ_NUM));
    assign w_in_win   = in_window(r_oldest, i_cmd.rx_ack, r_next_send);
    assign w_seq_ok   = (i_cmd.rx_seq == r_expected);
    // A cumulative ack inside the window frees everything up to and including it.
    assign w_freed    = w_in_win ? t_seq'(i_cmd.rx_ack - r_oldest + 1'b1) : '0;
    assign w_ack      = t_seq'(r_expected + SEQ_W'(MAX_SEQ_NUM));

    always_comb begin
        n_state     = r_state;
        n_next_send = r_next_send;
        n_oldest    = r_oldest;
        n_expected  = r_expected;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        o_cmd_ready = 1'b0;
        w_load      = 1'b0;
        w_buf_we    = 1'b0;
        w_res       = '0;
        w_res.kind  = KIND_STATUS;
        w_res.last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_ready = 1'b1;
                    w_load      = 1'b1;
                    case (i_cmd.op)
                        OP_PACKET: begin
                            if (w_full) begin
                                w_res.window_full_drop = 1'b1;
                            end else begin
                                w_buf_we          = 1'b1;
                                n_count           = r_count + 1'b1;
                                n_next_send       = r_next_send + 1'b1;
                                w_res.kind        = KIND_SEND;
                                w_res.frame_seq   = r_next_send;
                                w_res.frame_ack   = w_ack;
                                w_res.payload_out = i_cmd.payload;
                            end
                        end
                        OP_FRAME: begin
                            if (w_seq_ok) begin
                                n_expected        = r_expected + 1'b1;
                                w_res.kind        = KIND_DELIVER;
                                w_res.payload_out = i_cmd.payload;
                            end else begin
                                w_res.data_mismatch = 1'b1;
                            end
                            n_count                = r_count - w_freed;
                            n_oldest               = r_oldest + w_freed;
                            w_res.freed_count      = w_freed;
                            w_res.ack_out_of_range = !w_in_win;
                        end
                        OP_CKSUM_ERR: begin
                            w_res.checksum_error = 1'b1;
                        end
                        default: begin
                            // Timeout: replay the outstanding frames, oldest first.
                            if (r_count != '0) begin
                                w_load  = 1'b0;
                                n_ptr   = r_oldest;
                                n_left  = r_count;
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load            = 1'b1;
                    w_res.kind        = KIND_SEND;
                    w_res.frame_seq   = r_ptr;
                    w_res.frame_ack   = w_ack;
                    w_res.payload_out = r_rd_data;
                    w_res.last        = (r_left == t_seq'(1));
                    n_ptr             = r_ptr + 1'b1;
                    n_left            = r_left - 1'b1;
                    if (r_left == t_seq'(1)) begin
                        n_next_send = r_ptr + 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Enable reflects the window after this event.
        w_res.network_enable = (n_count < SEQ_W'(MAX_SEQ_NUM));

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_send <= '0;
            r_oldest    <= '0;
            r_expected  <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_send <= n_next_send;
            r_oldest    <= n_oldest;
            r_expected  <= n_expected;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_send_buf[r_next_send] <= i_cmd.payload;
        end
        r_rd_data <= r_send_buf[r_ptr];
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.result_kind      = r_out.kind;
    assign o_out.frame_seq        = r_out.frame_seq;
    assign o_out.frame_ack        = r_out.frame_ack;
    assign o_out.payload_out      = r_out.payload_out;
    assign o_out.freed_count      = r_out.freed_count;
    assign o_out.data_mismatch    = r_out.data_mismatch;
    assign o_out.ack_out_of_range = r_out.ack_out_of_range;
    assign o_out.checksum_error   = r_out.checksum_error;
    assign o_out.window_full_drop = r_out.window_full_drop;
    assign o_out.network_enable   = r_out.network_enable;
    assign o_out.last             = r_out.last;

endmodule

// ===== sv/gbn_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the link endpoint, and their bind.
// Depends on gbn_pkg and go_back_n_link_endpoint_core.
module gbn_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [1:0]                 i_kind,
    input logic [gbn_pkg::SEQ_W-1:0]  i_frame_seq,
    input logic [gbn_pkg::SEQ_W-1:0]  i_frame_ack,
    input logic [gbn_pkg::SEQ_W-1:0]  i_freed_count,
    input logic                       i_mismatch,
    input logic                       i_oor,
    input logic                       i_cksum,
    input logic                       i_drop,
    input logic                       i_last
);
    import gbn_pkg::*;

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_STATUS || i_kind == KIND_DELIVER) |-> i_last)
        else $error("status or deliver word not marked last");

    a_nonsend_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_SEND |-> i_frame_seq == '0 && i_frame_ack == '0)
        else $error("non-send word carries sequence or ack");

    a_send_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == KIND_SEND |->
            i_freed_count == '0 && !i_mismatch && !i_oor && !i_cksum && !i_drop)
        else $error("send word carries arrival or error flags");

endmodule

bind go_back_n_link_endpoint_core gbn_checker u_gbn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_kind        (o_out.result_kind),
    .i_frame_seq   (o_out.frame_seq),
    .i_frame_ack   (o_out.frame_ack),
    .i_freed_count (o_out.freed_count),
    .i_mismatch    (o_out.data_mismatch),
    .i_oor         (o_out.ack_out_of_range),
    .i_cksum       (o_out.checksum_error),
    .i_drop        (o_out.window_full_drop),
    .i_last        (o_out.last)
);
